>>> hdl/wbc_pkg.sv
// ----------------------------------------------------------------------------
// wbc_pkg
// Shared types and constants for the two-way write-back cache latency core.
// ----------------------------------------------------------------------------
package wbc_pkg;

  localparam int unsigned TagBits    = 2;
  localparam int unsigned IndexBits  = 1;
  localparam int unsigned OffsetBits = 4;
  localparam int unsigned NumSets    = 1 << IndexBits;
  localparam int unsigned NumWays    = 2;

  localparam int unsigned AddrW = 16;
  localparam int unsigned CfgW  = 8;
  localparam int unsigned LatW  = 11;
  localparam int unsigned SumW  = CfgW + 1;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic CfgIdxCache  = 1'b0;
  localparam logic CfgIdxMemory = 1'b1;

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqStore = 1'b1;

  typedef logic [IndexBits-1:0] set_idx_t;
  typedef logic [TagBits-1:0]   tag_t;

  // per-set state word, way 0 in the low slots
  typedef struct packed {
    logic                     recent;
    logic [NumWays-1:0][TagBits-1:0] tag;
    logic [NumWays-1:0]       dirty;
    logic [NumWays-1:0]       valid;
  } set_t;

endpackage

>>> hdl/two_way_writeback_cache_latency_core.sv
// ----------------------------------------------------------------------------
// two_way_writeback_cache_latency_core
// Tag-only two-way write-back, write-allocate cache latency model with
// per-set most-recently-used way.
//
//   channel  | dir | tdata (low bit up)                    | tuser
//   s_axis   | in  | address[15:0]                         | req_type
//   m_axis   | out | latency[10:0], hit, wrote_back, pad   | -
//   cfg      | in  | idx 0 cache_cycles, idx 1 memory_cycles
//
// After reset a clearing pass writes every set with s_axis_tready low. An
// accepted transfer reads its set, and ST_LOOK then updates the set and loads
// the output register; no new transfer is taken until this read-modify-write
// of the set memory is done. A stalled output holds the update step until
// m_axis_tready; a new transfer is taken while a result waits.
// ----------------------------------------------------------------------------
module two_way_writeback_cache_latency_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wbc_pkg::InDataW-1:0]   s_axis_tdata,   // address[15:0]
  input  logic                          s_axis_tuser,   // req_type
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [wbc_pkg::OutDataW-1:0]  m_axis_tdata,   // out_lat_q, hit, wrote_back, 0
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [wbc_pkg::CfgW-1:0]      cfg_data_i
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  state_e state_q, state_d;

  logic [wbc_pkg::CfgW-1:0] cache_cyc_q, mem_cyc_q;

  wbc_pkg::set_idx_t clr_idx_q, clr_idx_d;
  logic              req_store_q;
  wbc_pkg::set_idx_t req_set_q;
  wbc_pkg::tag_t     req_tag_q;

  logic                    out_valid_q, out_valid_d;
  logic [wbc_pkg::LatW-1:0] out_lat_q, out_lat_d;
  logic                    out_hit_q, out_hit_d;
  logic                    out_wb_q, out_wb_d;

  logic              s_accept;
  logic              out_free;
  logic              mem_we;
  wbc_pkg::set_idx_t mem_waddr;
  wbc_pkg::set_t     mem_wdata;
  wbc_pkg::set_t     rd_set;
  wbc_pkg::set_t     upd_set;

  logic                     hit0, hit1, hit, wb, way;
  logic [wbc_pkg::SumW-1:0] cyc_sum;
  logic [wbc_pkg::LatW-1:0] lat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  wbc_set_mem u_set_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (s_accept),
    .raddr_i (s_axis_tdata[wbc_pkg::OffsetBits +: wbc_pkg::IndexBits]),
    .rdata_o (rd_set)
  );

  // lookup and replacement decision
  always_comb begin
    hit0    = rd_set.valid[0] && (rd_set.tag[0] == req_tag_q);
    hit1    = rd_set.valid[1] && (rd_set.tag[1] == req_tag_q);
    hit     = hit0 || hit1;
    wb      = 1'b0;
    upd_set = rd_set;
    if (hit) begin
      way = !hit0;
      if (req_store_q == wbc_pkg::ReqStore) begin
        upd_set.dirty[way] = 1'b1;
      end
    end else begin
      if (!rd_set.valid[0]) begin
        way = 1'b0;
      end else if (!rd_set.valid[1]) begin
        way = 1'b1;
      end else begin
        way = !rd_set.recent;
        wb  = rd_set.dirty[way];
      end
      upd_set.valid[way] = 1'b1;
      upd_set.dirty[way] = (req_store_q == wbc_pkg::ReqStore);
      upd_set.tag[way]   = req_tag_q;
    end
    upd_set.recent = way;
  end

  always_comb begin
    cyc_sum = {1'b0, cache_cyc_q} + {1'b0, mem_cyc_q};
    if (hit) begin
      lat = {{(wbc_pkg::LatW - wbc_pkg::CfgW){1'b0}}, cache_cyc_q};
    end else if (wb) begin
      lat = {cyc_sum, 2'b00};
    end else begin
      lat = {1'b0, cyc_sum, 1'b0};
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_lat_d   = out_lat_q;
    out_hit_d   = out_hit_q;
    out_wb_d    = out_wb_q;
    mem_we      = 1'b0;
    mem_waddr   = req_set_q;
    mem_wdata   = upd_set;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (&clr_idx_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          mem_we      = 1'b1;
          out_valid_d = 1'b1;
          out_lat_d   = lat;
          out_hit_d   = hit;
          out_wb_d    = wb;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_lat_q <= out_lat_d;
    out_hit_q <= out_hit_d;
    out_wb_q  <= out_wb_d;
    if (s_accept) begin
      req_store_q <= s_axis_tuser;
      req_set_q   <= s_axis_tdata[wbc_pkg::OffsetBits +: wbc_pkg::IndexBits];
      req_tag_q   <= s_axis_tdata[wbc_pkg::OffsetBits + wbc_pkg::IndexBits +: wbc_pkg::TagBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_cyc_q <= wbc_pkg::CfgW'(1);
      mem_cyc_q   <= wbc_pkg::CfgW'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wbc_pkg::CfgIdxCache:  cache_cyc_q <= cfg_data_i;
        wbc_pkg::CfgIdxMemory: mem_cyc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(wbc_pkg::OutDataW - wbc_pkg::LatW - 2){1'b0}},
                          out_wb_q, out_hit_q, out_lat_q};

`ifndef ASSERT_OFF
  a_look_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q == ST_LOOK)
    else $error("no lookup after accepted transfer");

  a_result_from_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_LOOK))
    else $error("result without lookup");

  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_hit_q && out_wb_q))
    else $error("writeback flagged on a hit");

  a_write_when_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR) || (state_q == ST_LOOK && out_free))
    else $error("set memory written outside clear or update");

  a_no_ready_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready)
    else $error("input ready during clearing pass");
`endif

endmodule

>>> hdl/wbc_set_mem.sv
// ----------------------------------------------------------------------------
// wbc_set_mem
// Set state memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wbc_set_mem (
  input  logic              clk_i,
  input  logic              we_i,
  input  wbc_pkg::set_idx_t waddr_i,
  input  wbc_pkg::set_t     wdata_i,
  input  logic              re_i,
  input  wbc_pkg::set_idx_t raddr_i,
  output wbc_pkg::set_t     rdata_o
);

  wbc_pkg::set_t mem_q [wbc_pkg::NumSets];
  wbc_pkg::set_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> dv/tb_two_way_writeback_cache_latency_core.sv
// ----------------------------------------------------------------------------
// tb_two_way_writeback_cache_latency_core
// Self-checking bench for the two-way write-back cache latency core. Requests
// go in on the slave stream and results come back on the master stream. A
// scoreboard keeps its own copy of the tags and line state, predicts the
// latency and flags of each accepted request, and checks every result. A short
// directed sequence covers fills, hits, clean and dirty evictions and address
// extremes. Random traffic then runs under several latency settings, with
// random stalls on both streams except in the last phase.
// ----------------------------------------------------------------------------
module tb_two_way_writeback_cache_latency_core;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases  = 5;
  localparam int unsigned PhaseItems = 130;

  typedef struct packed {
    logic [wbc_pkg::LatW-1:0] latency;
    logic                     hit;
    logic                     wrote_back;
  } cache_resp_t;

  class cache_latency_scoreboard;
    logic [wbc_pkg::CfgW-1:0] cache_cycles;
    logic [wbc_pkg::CfgW-1:0] memory_cycles;
    logic            line_valid [wbc_pkg::NumWays][wbc_pkg::NumSets];
    logic            line_dirty [wbc_pkg::NumWays][wbc_pkg::NumSets];
    wbc_pkg::tag_t   line_tag   [wbc_pkg::NumWays][wbc_pkg::NumSets];
    logic            recent_way [wbc_pkg::NumSets];
    cache_resp_t     expected_q [$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     hits;
    int unsigned     writebacks;

    function new();
      cache_cycles  = 8'd1;
      memory_cycles = 8'd10;
      for (int w = 0; w < wbc_pkg::NumWays; w++) begin
        for (int s = 0; s < wbc_pkg::NumSets; s++) begin
          line_valid[w][s] = 1'b0;
          line_dirty[w][s] = 1'b0;
          line_tag[w][s]   = '0;
        end
      end
      for (int s = 0; s < wbc_pkg::NumSets; s++) recent_way[s] = 1'b0;
      errors     = 0;
      checked    = 0;
      hits       = 0;
      writebacks = 0;
    endfunction

    function void write_register(logic idx, logic [wbc_pkg::CfgW-1:0] value);
      if (idx == wbc_pkg::CfgIdxCache) begin
        cache_cycles = value;
      end else begin
        memory_cycles = value;
      end
    endfunction

    function void note_request(logic req_type, logic [wbc_pkg::AddrW-1:0] addr);
      wbc_pkg::set_idx_t s;
      wbc_pkg::tag_t     t;
      int unsigned       way;
      int unsigned       fill;
      cache_resp_t       r;
      s    = addr[wbc_pkg::OffsetBits +: wbc_pkg::IndexBits];
      t    = addr[wbc_pkg::OffsetBits+wbc_pkg::IndexBits +: wbc_pkg::TagBits];
      fill = 2 * (int'(cache_cycles) + int'(memory_cycles));
      r    = '0;
      way  = 0;
      if (line_valid[0][s] && line_tag[0][s] == t) begin
        r.hit = 1'b1;
        way   = 0;
      end else if (line_valid[1][s] && line_tag[1][s] == t) begin
        r.hit = 1'b1;
        way   = 1;
      end
      if (r.hit) begin
        recent_way[s] = way[0];
        if (req_type == wbc_pkg::ReqStore) line_dirty[way][s] = 1'b1;
        r.latency = wbc_pkg::LatW'(cache_cycles);
      end else begin
        if (!line_valid[0][s]) begin
          way = 0;
        end else if (!line_valid[1][s]) begin
          way = 1;
        end else begin
          way          = recent_way[s] ? 0 : 1;
          r.wrote_back = line_dirty[way][s];
        end
        recent_way[s]      = way[0];
        line_valid[way][s] = 1'b1;
        line_dirty[way][s] = (req_type == wbc_pkg::ReqStore);
        line_tag[way][s]   = t;
        r.latency = r.wrote_back ? wbc_pkg::LatW'(2 * fill) : wbc_pkg::LatW'(fill);
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [wbc_pkg::OutDataW-1:0] data);
      cache_resp_t got;
      cache_resp_t exp;
      got.latency    = data[wbc_pkg::LatW-1:0];
      got.hit        = data[wbc_pkg::LatW];
      got.wrote_back = data[wbc_pkg::LatW+1];
      if (expected_q.size() == 0) begin
        $error("unexpected result, tdata=%h", data);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (exp.hit) hits++;
      if (exp.wrote_back) writebacks++;
      if (got.latency !== exp.latency) begin
        $error("latency: expected %0d, actual %0d", exp.latency, got.latency);
        errors++;
      end
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0b, actual %0b", exp.hit, got.hit);
        errors++;
      end
      if (got.wrote_back !== exp.wrote_back) begin
        $error("wrote_back: expected %0b, actual %0b", exp.wrote_back, got.wrote_back);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [wbc_pkg::InDataW-1:0]  s_axis_tdata;
  logic                         s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [wbc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         cfg_we_i;
  logic                         cfg_idx_i;
  logic [wbc_pkg::CfgW-1:0]     cfg_data_i;

  cache_latency_scoreboard sb;
  bit                      stall_en = 1'b1;
  int unsigned             cycle_cnt = 0;

  two_way_writeback_cache_latency_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_request(logic req_type, logic [wbc_pkg::AddrW-1:0] addr,
                              bit gaps_on);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= wbc_pkg::InDataW'($urandom);
      s_axis_tuser  <= 1'($urandom);
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= req_type;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req_type, addr);
    @(negedge clk_i);
  endtask

  task automatic program_latency(logic [wbc_pkg::CfgW-1:0] c,
                                 logic [wbc_pkg::CfgW-1:0] m);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= wbc_pkg::CfgIdxCache;
    cfg_data_i <= c;
    @(posedge clk_i);
    sb.write_register(wbc_pkg::CfgIdxCache, c);
    @(negedge clk_i);
    cfg_idx_i  <= wbc_pkg::CfgIdxMemory;
    cfg_data_i <= m;
    @(posedge clk_i);
    sb.write_register(wbc_pkg::CfgIdxMemory, m);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // random traffic; a quarter of requests repeat the last address to force hits
  task automatic run_random(int unsigned n, bit gaps_on);
    logic [wbc_pkg::AddrW-1:0] addr;
    logic                      req_type;
    addr = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(0, 3) != 0) begin
        addr = wbc_pkg::AddrW'($urandom_range(0, 65535));
      end
      req_type = ($urandom_range(0, 1) == 1) ? wbc_pkg::ReqStore : wbc_pkg::ReqLoad;
      send_request(req_type, addr, gaps_on);
    end
  endtask

  initial begin
    logic [wbc_pkg::AddrW-1:0] dir_addr [16];
    logic                      dir_type [16];
    logic [wbc_pkg::CfgW-1:0]  c_val;
    logic [wbc_pkg::CfgW-1:0]  m_val;

    // fill, hit and dirty evictions in both sets, a clean eviction in set 0, address extremes
    dir_addr = '{16'h0000, 16'h0000, 16'h0020, 16'h0000, 16'h0040, 16'h0060,
                 16'h0040, 16'h0000, 16'hFFFF, 16'hFFEF, 16'h0110, 16'h0010,
                 16'hFF9F, 16'h0070, 16'h0030, 16'h0050};
    dir_type = '{wbc_pkg::ReqLoad,  wbc_pkg::ReqLoad,  wbc_pkg::ReqStore, wbc_pkg::ReqStore,
                 wbc_pkg::ReqLoad,  wbc_pkg::ReqLoad,  wbc_pkg::ReqLoad,  wbc_pkg::ReqLoad,
                 wbc_pkg::ReqStore, wbc_pkg::ReqLoad,  wbc_pkg::ReqLoad,  wbc_pkg::ReqLoad,
                 wbc_pkg::ReqStore, wbc_pkg::ReqLoad,  wbc_pkg::ReqStore, wbc_pkg::ReqLoad};

    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = wbc_pkg::ReqLoad;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = wbc_pkg::CfgIdxCache;
    cfg_data_i    = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 16; i++) send_request(dir_type[i], dir_addr[i], 1'b1);
    s_axis_tvalid <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      case (p)
        0: begin c_val = 8'd255; m_val = 8'd255; end
        1: begin c_val = 8'd0;   m_val = 8'd0;   end
        2: begin c_val = 8'd0;   m_val = 8'd255; end
        3: begin c_val = 8'd255; m_val = 8'd0;   end
        default: begin
          c_val = wbc_pkg::CfgW'($urandom);
          m_val = wbc_pkg::CfgW'($urandom);
        end
      endcase
      program_latency(c_val, m_val);
      if (p == NumPhases - 1) stall_en = 1'b0;
      run_random(PhaseItems, p != NumPhases - 1);
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Checked %0d requests under reset and %0d programmed latency settings.",
             sb.checked, NumPhases);
    $display("Among them %0d hits and %0d dirty evictions; %0d mismatches.",
             sb.hits, sb.writebacks, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/wbc_pkg.sv
hdl/wbc_set_mem.sv
hdl/two_way_writeback_cache_latency_core.sv
dv/tb_two_way_writeback_cache_latency_core.sv
